/* hw/rtl/pru_pkg.sv */
// Package for the pump and refill controller: mode and opcode codes,
// configuration register indexes, reset values and field widths.
// No dependencies.
`default_nettype none

package pru_pkg;

  // Default width of the saturating elapsed-time counters.
  localparam int DEF_COUNTER_WIDTH = 16;

  localparam int MODE_W   = 3;
  localparam int OP_W     = 2;
  localparam int LEVEL_W  = 8;
  localparam int TIME_W   = 16;
  localparam int CFG_IDX_W = 3;

  // Operating modes.
  localparam logic [MODE_W-1:0] MODE_WAIT        = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUMP        = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REFILL_ONLY = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REFILL_PUMP = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ERROR       = 3'd4;

  // Request kinds.
  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_CONTROL = 2'd1;
  localparam logic [OP_W-1:0] OP_STATUS  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PUMP_TIMEOUT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFILL_TIMEOUT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRESHNESS_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_COOLDOWN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_EXIT_LEVEL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_ENTER_LEVEL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VARIANCE_MARGIN   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_NODE       = 3'd7;

  // Reset values of the configuration registers.
  localparam logic [TIME_W-1:0]  RST_PUMP_TIMEOUT      = 16'd180;
  localparam logic [TIME_W-1:0]  RST_REFILL_TIMEOUT    = 16'd600;
  localparam logic [TIME_W-1:0]  RST_FRESHNESS_LIMIT   = 16'd3;
  localparam logic [TIME_W-1:0]  RST_EMPTY_COOLDOWN    = 16'd20;
  localparam logic [LEVEL_W-1:0] RST_EMPTY_EXIT_LEVEL  = 8'd210;
  localparam logic [LEVEL_W-1:0] RST_EMPTY_ENTER_LEVEL = 8'd205;
  localparam logic [LEVEL_W-1:0] RST_VARIANCE_MARGIN   = 8'd10;
  localparam logic [LEVEL_W-1:0] RST_ACCEPT_NODE       = 8'd255;

endpackage

`default_nettype wire

/* hw/rtl/pump_refill_controller_unit.sv */
// Top level of the pump and refill controller.
// Depends on pru_pkg for mode, opcode and register codes and reset values.
`default_nettype none

// Pump and refill controller. Each request on the s_ side is a time tick, a
// control step with a source level sample, or a status message from a node;
// every request yields one result on the m_ side showing the mode, the pump
// and refill drives, the empty-source flag and the filtered level after that
// request. Requests pass an input register, combinational logic and a result
// register: a request waits in the input register until the result register
// can take it, and while m_tready stays high a request is taken every cycle.
// While a result waits for m_tready the input register holds one more request
// and then s_tready stays low until the result is taken. Configuration
// registers are written through cfg_we/cfg_index/cfg_data and should only be
// changed while no request is in flight.
module pump_refill_controller_unit #(
  parameter int COUNTER_WIDTH = pru_pkg::DEF_COUNTER_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // fill_level[7:0], source_node[15:8], payload_length[23:16], status_byte[31:24]
  input  wire logic [31:0]                    s_tdata,
  // opcode[1:0]
  input  wire logic [pru_pkg::OP_W-1:0]       s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // mode[2:0], pump_drive[3], refill_drive[4], source_empty[5],
  // filtered_level[13:6], zero[15:14]
  output logic [15:0]                         m_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [pru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pru_pkg::TIME_W-1:0]     cfg_data
);

  import pru_pkg::*;

  localparam int CMP_W = (COUNTER_WIDTH > TIME_W) ? COUNTER_WIDTH : TIME_W;
  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

  // Configuration registers.
  logic [TIME_W-1:0]  pump_timeout;
  logic [TIME_W-1:0]  refill_timeout;
  logic [TIME_W-1:0]  freshness_limit;
  logic [TIME_W-1:0]  empty_cooldown;
  logic [LEVEL_W-1:0] empty_exit_level;
  logic [LEVEL_W-1:0] empty_enter_level;
  logic [LEVEL_W-1:0] variance_margin;
  logic [LEVEL_W-1:0] accept_node;

  always_ff @(posedge clk) begin
    if (rst) begin
      pump_timeout      <= RST_PUMP_TIMEOUT;
      refill_timeout    <= RST_REFILL_TIMEOUT;
      freshness_limit   <= RST_FRESHNESS_LIMIT;
      empty_cooldown    <= RST_EMPTY_COOLDOWN;
      empty_exit_level  <= RST_EMPTY_EXIT_LEVEL;
      empty_enter_level <= RST_EMPTY_ENTER_LEVEL;
      variance_margin   <= RST_VARIANCE_MARGIN;
      accept_node       <= RST_ACCEPT_NODE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PUMP_TIMEOUT:      pump_timeout      <= cfg_data;
        REG_REFILL_TIMEOUT:    refill_timeout    <= cfg_data;
        REG_FRESHNESS_LIMIT:   freshness_limit   <= cfg_data;
        REG_EMPTY_COOLDOWN:    empty_cooldown    <= cfg_data;
        REG_EMPTY_EXIT_LEVEL:  empty_exit_level  <= cfg_data[LEVEL_W-1:0];
        REG_EMPTY_ENTER_LEVEL: empty_enter_level <= cfg_data[LEVEL_W-1:0];
        REG_VARIANCE_MARGIN:   variance_margin   <= cfg_data[LEVEL_W-1:0];
        REG_ACCEPT_NODE:       accept_node       <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic             in_valid;
  logic [OP_W-1:0]  in_op;
  logic [31:0]      in_data;
  logic             advance;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op   <= s_tuser;
      in_data <= s_tdata;
    end
  end

  logic [LEVEL_W-1:0] fill_level;
  logic [LEVEL_W-1:0] source_node;
  logic [LEVEL_W-1:0] payload_length;
  logic [LEVEL_W-1:0] status_byte;

  assign fill_level     = in_data[7:0];
  assign source_node    = in_data[15:8];
  assign payload_length = in_data[23:16];
  assign status_byte    = in_data[31:24];

  // Controller state.
  logic [MODE_W-1:0]        mode_reg, mode_reg_next;
  logic                     pump_is_on, pump_is_on_next;
  logic                     refill_is_on, refill_is_on_next;
  logic [LEVEL_W-1:0]       level_avg, level_avg_next;
  logic [LEVEL_W-1:0]       fast_variance, fast_variance_next;
  logic [LEVEL_W-1:0]       slow_variance, slow_variance_next;
  logic                     empty_flag, empty_flag_next;
  logic                     target_error, target_error_next;
  logic                     target_full, target_full_next;
  logic                     target_empty, target_empty_next;
  logic [COUNTER_WIDTH-1:0] since_pump_on, since_pump_on_next;
  logic [COUNTER_WIDTH-1:0] since_refill_on, since_refill_on_next;
  logic [COUNTER_WIDTH-1:0] since_update, since_update_next;
  logic [COUNTER_WIDTH-1:0] since_empty_stop, since_empty_stop_next;

  // Counters and limits compared at a common width.
  logic [CMP_W-1:0] pump_cnt_x, refill_cnt_x, update_cnt_x, stop_cnt_x;
  assign pump_cnt_x   = CMP_W'(since_pump_on);
  assign refill_cnt_x = CMP_W'(since_refill_on);
  assign update_cnt_x = CMP_W'(since_update);
  assign stop_cnt_x   = CMP_W'(since_empty_stop);

  logic cooldown_active, pump_timed_out, refill_timed_out, status_stale;
  assign cooldown_active  = stop_cnt_x < CMP_W'(empty_cooldown);
  assign pump_timed_out   = pump_cnt_x > CMP_W'(pump_timeout);
  assign refill_timed_out = refill_cnt_x > CMP_W'(refill_timeout);
  assign status_stale     = !(update_cnt_x < CMP_W'(freshness_limit));

  // Filter datapath for a control step.
  logic [LEVEL_W-1:0] seed_avg;
  logic [LEVEL_W-1:0] dev;
  logic [9:0]         avg_sum;
  logic [9:0]         fast_sum;
  logic [11:0]        slow_sum;
  logic [LEVEL_W-1:0] new_avg, new_fast, new_slow;
  logic               new_empty;
  logic               var_spike;

  always_comb begin
    seed_avg = (level_avg == '0) ? fill_level : level_avg;
    dev      = (fill_level < seed_avg) ? seed_avg - fill_level : fill_level - seed_avg;
    avg_sum  = {2'b00, seed_avg} + {1'b0, seed_avg, 1'b0} + {2'b00, fill_level};
    fast_sum = {2'b00, fast_variance} + {1'b0, fast_variance, 1'b0} + {2'b00, dev};
    slow_sum = ({slow_variance, 4'b0000} - {4'b0000, slow_variance}) + {4'b0000, dev};
    new_avg  = avg_sum[9:2];
    new_fast = fast_sum[9:2];
    new_slow = slow_sum[11:4];
    if (empty_flag && (new_avg > empty_exit_level)) begin
      new_empty = 1'b0;
    end else if (!empty_flag && (new_avg < empty_enter_level)) begin
      new_empty = 1'b1;
    end else begin
      new_empty = empty_flag;
    end
    var_spike = (new_fast > new_slow) && ((new_fast - new_slow) > variance_margin);
  end

  // Mode machine and request handling.
  logic [MODE_W-1:0] mode_sel;
  logic              want_pump, want_refill;

  always_comb begin
    mode_reg_next         = mode_reg;
    pump_is_on_next       = pump_is_on;
    refill_is_on_next     = refill_is_on;
    level_avg_next        = level_avg;
    fast_variance_next    = fast_variance;
    slow_variance_next    = slow_variance;
    empty_flag_next       = empty_flag;
    target_error_next     = target_error;
    target_full_next      = target_full;
    target_empty_next     = target_empty;
    since_pump_on_next    = since_pump_on;
    since_refill_on_next  = since_refill_on;
    since_update_next     = since_update;
    since_empty_stop_next = since_empty_stop;
    mode_sel              = mode_reg;
    want_pump             = 1'b0;
    want_refill           = 1'b0;

    case (in_op)
      OP_TICK: begin
        if (since_pump_on != CNT_MAX) since_pump_on_next = since_pump_on + 1'b1;
        if (since_refill_on != CNT_MAX) since_refill_on_next = since_refill_on + 1'b1;
        if (since_update != CNT_MAX) since_update_next = since_update + 1'b1;
        if (since_empty_stop != CNT_MAX) since_empty_stop_next = since_empty_stop + 1'b1;
      end
      OP_CONTROL: begin
        level_avg_next     = new_avg;
        fast_variance_next = new_fast;
        slow_variance_next = new_slow;
        empty_flag_next    = new_empty;
        case (mode_reg)
          MODE_WAIT: begin
            if (target_empty) begin
              mode_sel = (new_empty || cooldown_active) ? MODE_REFILL_ONLY : MODE_PUMP;
            end
          end
          MODE_PUMP: begin
            if (new_empty) begin
              since_empty_stop_next = '0;
              mode_sel = MODE_WAIT;
            end else if (target_full) begin
              mode_sel = MODE_WAIT;
            end else if (pump_timed_out) begin
              mode_sel = MODE_ERROR;
            end
          end
          MODE_REFILL_ONLY: begin
            if (refill_timed_out) begin
              mode_sel = MODE_ERROR;
            end else if (!new_empty && !cooldown_active) begin
              mode_sel = MODE_REFILL_PUMP;
            end
          end
          MODE_REFILL_PUMP: begin
            if (refill_timed_out) begin
              mode_sel = MODE_ERROR;
            end else if (new_empty || var_spike) begin
              since_empty_stop_next = '0;
              mode_sel = MODE_REFILL_ONLY;
            end
          end
          default: ;
        endcase
        // A target that is full, failing or silent overrides everything.
        if (target_full || target_error || status_stale) begin
          mode_sel = MODE_WAIT;
        end
        mode_reg_next = mode_sel;
        want_pump     = (mode_sel == MODE_PUMP) || (mode_sel == MODE_REFILL_PUMP);
        want_refill   = (mode_sel == MODE_REFILL_ONLY) || (mode_sel == MODE_REFILL_PUMP);
        if (want_pump && !pump_is_on) since_pump_on_next = '0;
        if (want_refill && !refill_is_on) since_refill_on_next = '0;
        pump_is_on_next   = want_pump;
        refill_is_on_next = want_refill;
      end
      OP_STATUS: begin
        if ((payload_length != '0) && (source_node == accept_node)) begin
          target_error_next = status_byte[7];
          target_full_next  = status_byte[0];
          target_empty_next = !status_byte[1];
          since_update_next = '0;
        end
      end
      default: ;
    endcase
  end

  logic step;
  assign step = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg         <= MODE_WAIT;
      pump_is_on       <= 1'b0;
      refill_is_on     <= 1'b0;
      level_avg        <= '0;
      fast_variance    <= '0;
      slow_variance    <= '0;
      empty_flag       <= 1'b0;
      target_error     <= 1'b1;
      target_full      <= 1'b1;
      target_empty     <= 1'b0;
      since_pump_on    <= '0;
      since_refill_on  <= '0;
      since_update     <= '0;
      since_empty_stop <= '0;
    end else if (step) begin
      mode_reg         <= mode_reg_next;
      pump_is_on       <= pump_is_on_next;
      refill_is_on     <= refill_is_on_next;
      level_avg        <= level_avg_next;
      fast_variance    <= fast_variance_next;
      slow_variance    <= slow_variance_next;
      empty_flag       <= empty_flag_next;
      target_error     <= target_error_next;
      target_full      <= target_full_next;
      target_empty     <= target_empty_next;
      since_pump_on    <= since_pump_on_next;
      since_refill_on  <= since_refill_on_next;
      since_update     <= since_update_next;
      since_empty_stop <= since_empty_stop_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {2'b00, level_avg_next, empty_flag_next, refill_is_on_next,
                  pump_is_on_next, mode_reg_next};
    end
  end

endmodule

`default_nettype wire

/* tb/pump_refill_controller_unit_tb.sv */
// Self-checking testbench for pump_refill_controller_unit: directed and random
// requests with a cycle-free predictor of the controller, checked field by field.
// Depends on pru_pkg and the controller RTL.
`default_nettype none

module pump_refill_controller_unit_tb;
  import pru_pkg::*;

  // A narrow counter width keeps the saturation test short.
  localparam int COUNTER_WIDTH = 8;
  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES = 4;
  localparam int SWEEP_ITEMS = 100;
  localparam longint RUN_LIMIT = 4_000_000;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [LEVEL_W-1:0] fill;
    logic [7:0]         src;
    logic [7:0]         len;
    logic [7:0]         sb;
  } plant_req_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic               pump;
    logic               refill;
    logic               empty;
    logic [LEVEL_W-1:0] level;
  } plant_out_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [31:0]          s_tdata = '0;
  logic [OP_W-1:0]      s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [15:0]          m_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIME_W-1:0]    cfg_data = '0;

  pump_refill_controller_unit #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted controller state and its copy of the settings.
  logic [TIME_W-1:0]        set_pump_to, set_refill_to, set_fresh, set_cool;
  logic [LEVEL_W-1:0]       set_exit, set_enter, set_margin, set_node;
  logic [MODE_W-1:0]        cur_mode;
  logic                     pump_on, refill_on, src_empty;
  logic                     tgt_err, tgt_full, tgt_empty;
  logic [LEVEL_W-1:0]       lvl_avg, var_fast, var_slow;
  logic [COUNTER_WIDTH-1:0] t_pump, t_refill, t_update, t_estop;

  plant_out_t pending_status[$];
  int         mismatch_count = 0;

  // Stimulus pacing shared by the tasks and the sink process.
  bit steady_feed = 1'b0;
  int burst_left = 0;
  int sink_style = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int sink_phase = 0;

  task automatic reset_plant();
    set_pump_to   = RST_PUMP_TIMEOUT;
    set_refill_to = RST_REFILL_TIMEOUT;
    set_fresh     = RST_FRESHNESS_LIMIT;
    set_cool      = RST_EMPTY_COOLDOWN;
    set_exit      = RST_EMPTY_EXIT_LEVEL;
    set_enter     = RST_EMPTY_ENTER_LEVEL;
    set_margin    = RST_VARIANCE_MARGIN;
    set_node      = RST_ACCEPT_NODE;
    cur_mode  = MODE_WAIT;
    pump_on   = 1'b0;
    refill_on = 1'b0;
    src_empty = 1'b0;
    tgt_err   = 1'b1;
    tgt_full  = 1'b1;
    tgt_empty = 1'b0;
    lvl_avg   = '0;
    var_fast  = '0;
    var_slow  = '0;
    t_pump    = '0;
    t_refill  = '0;
    t_update  = '0;
    t_estop   = '0;
  endtask

  function automatic plant_out_t advance_plant(input plant_req_t r);
    plant_out_t        o;
    int                sample;
    int                dev;
    logic [MODE_W-1:0] nxt;
    logic              cooling;
    logic              want_pump;
    logic              want_refill;
    case (r.op)
      OP_TICK: begin
        if (t_pump != CNT_MAX) t_pump = t_pump + 1'b1;
        if (t_refill != CNT_MAX) t_refill = t_refill + 1'b1;
        if (t_update != CNT_MAX) t_update = t_update + 1'b1;
        if (t_estop != CNT_MAX) t_estop = t_estop + 1'b1;
      end
      OP_CONTROL: begin
        sample = int'(r.fill);
        nxt = cur_mode;
        // A zero average means no sample has been seen yet.
        if (lvl_avg == 0) lvl_avg = r.fill;
        dev = (sample < lvl_avg) ? lvl_avg - sample : sample - lvl_avg;
        lvl_avg  = LEVEL_W'((3 * lvl_avg + sample) / 4);
        var_fast = LEVEL_W'((3 * var_fast + dev) / 4);
        var_slow = LEVEL_W'((15 * var_slow + dev) / 16);
        if (src_empty && lvl_avg > set_exit) src_empty = 1'b0;
        else if (!src_empty && lvl_avg < set_enter) src_empty = 1'b1;
        cooling = (t_estop < set_cool);
        case (cur_mode)
          MODE_WAIT: begin
            if (tgt_empty) nxt = (src_empty || cooling) ? MODE_REFILL_ONLY : MODE_PUMP;
          end
          MODE_PUMP: begin
            if (src_empty) begin
              t_estop = '0;
              nxt = MODE_WAIT;
            end else if (tgt_full) begin
              nxt = MODE_WAIT;
            end else if (t_pump > set_pump_to) begin
              nxt = MODE_ERROR;
            end
          end
          MODE_REFILL_ONLY: begin
            if (t_refill > set_refill_to) nxt = MODE_ERROR;
            else if (!src_empty && !cooling) nxt = MODE_REFILL_PUMP;
          end
          MODE_REFILL_PUMP: begin
            if (t_refill > set_refill_to) begin
              nxt = MODE_ERROR;
            end else if (src_empty || (var_fast > var_slow &&
                         var_fast - var_slow > set_margin)) begin
              t_estop = '0;
              nxt = MODE_REFILL_ONLY;
            end
          end
          default: ;
        endcase
        if (tgt_full || tgt_err || !(t_update < set_fresh)) nxt = MODE_WAIT;
        cur_mode = nxt;
        want_pump = (nxt == MODE_PUMP || nxt == MODE_REFILL_PUMP);
        want_refill = (nxt == MODE_REFILL_ONLY || nxt == MODE_REFILL_PUMP);
        if (want_pump && !pump_on) t_pump = '0;
        if (want_refill && !refill_on) t_refill = '0;
        pump_on = want_pump;
        refill_on = want_refill;
      end
      OP_STATUS: begin
        if (r.len != 0 && r.src == set_node) begin
          tgt_err   = r.sb[7];
          tgt_full  = r.sb[0];
          tgt_empty = !r.sb[1];
          t_update  = '0;
        end
      end
      default: ;
    endcase
    o.mode   = cur_mode;
    o.pump   = pump_on;
    o.refill = refill_on;
    o.empty  = src_empty;
    o.level  = lvl_avg;
    return o;
  endfunction

  function automatic plant_req_t req(input logic [OP_W-1:0] op, input int fill, input int src,
                                     input int len, input int sb);
    plant_req_t r;
    r.op   = op;
    r.fill = fill[7:0];
    r.src  = src[7:0];
    r.len  = len[7:0];
    r.sb   = sb[7:0];
    return r;
  endfunction

  task automatic check_field(input string what, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // Results are compared at the edge that accepts them; requests are predicted
  // at the edge that accepts them.
  always @(posedge clk) begin : result_watch
    plant_out_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_status.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
          mismatch_count++;
        end else begin
          want = pending_status.pop_front();
          check_field("mode", 8'(want.mode), 8'(m_tdata[2:0]));
          check_field("pump_drive", 8'(want.pump), 8'(m_tdata[3]));
          check_field("refill_drive", 8'(want.refill), 8'(m_tdata[4]));
          check_field("source_empty", 8'(want.empty), 8'(m_tdata[5]));
          check_field("filtered_level", want.level, m_tdata[13:6]);
          check_field("padding", 8'd0, 8'(m_tdata[15:14]));
        end
      end
      if (s_tvalid && s_tready)
        pending_status.push_back(advance_plant(req(s_tuser, int'(s_tdata[7:0]),
                                                   int'(s_tdata[15:8]),
                                                   int'(s_tdata[23:16]),
                                                   int'(s_tdata[31:24]))));
    end
  end

  // Result sink: a long hold-off when asked, otherwise one of three ready styles.
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      sink_phase <= (sink_phase == 6) ? 0 : sink_phase + 1;
      case (sink_style)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= (sink_phase > 2);
      endcase
    end
  end

  task automatic send_request(input plant_req_t r);
    if (!steady_feed && burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end else if (burst_left > 0) begin
      burst_left--;
    end
    s_tvalid <= 1'b1;
    s_tuser <= r.op;
    s_tdata <= {r.sb, r.len, r.src, r.fill};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_we high; load_settings lowers it after the last register.
  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[TIME_W-1:0];
    case (idx)
      REG_PUMP_TIMEOUT:      set_pump_to   = val[15:0];
      REG_REFILL_TIMEOUT:    set_refill_to = val[15:0];
      REG_FRESHNESS_LIMIT:   set_fresh     = val[15:0];
      REG_EMPTY_COOLDOWN:    set_cool      = val[15:0];
      REG_EMPTY_EXIT_LEVEL:  set_exit      = val[7:0];
      REG_EMPTY_ENTER_LEVEL: set_enter     = val[7:0];
      REG_VARIANCE_MARGIN:   set_margin    = val[7:0];
      REG_ACCEPT_NODE:       set_node      = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_settings(input int pump_to, input int refill_to, input int fresh,
                               input int cool, input int exit_lvl, input int enter_lvl,
                               input int margin, input int node);
    write_setting(REG_PUMP_TIMEOUT, pump_to);
    write_setting(REG_REFILL_TIMEOUT, refill_to);
    write_setting(REG_FRESHNESS_LIMIT, fresh);
    write_setting(REG_EMPTY_COOLDOWN, cool);
    write_setting(REG_EMPTY_EXIT_LEVEL, exit_lvl);
    write_setting(REG_EMPTY_ENTER_LEVEL, enter_lvl);
    write_setting(REG_VARIANCE_MARGIN, margin);
    write_setting(REG_ACCEPT_NODE, node);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed traffic from the configured node, levels near the
  // hysteresis band, and full-range noise in every field.
  function automatic plant_req_t random_request();
    plant_req_t r;
    int         pick;
    int         lo;
    int         hi;
    r.fill = 8'($urandom);
    r.src  = 8'($urandom);
    r.len  = 8'($urandom);
    r.sb   = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      r.op = OP_TICK;
    end else if (pick < 78) begin
      r.op = OP_CONTROL;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        lo = (set_enter > 25) ? set_enter - 25 : 1;
        hi = (set_exit < 230) ? set_exit + 25 : 255;
        if (hi < lo) hi = lo;
        r.fill = 8'($urandom_range(lo, hi));
      end else if (pick == 7) begin
        r.fill = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
    end else if (pick < 97) begin
      r.op = OP_STATUS;
      if ($urandom_range(0, 99) < 85) r.src = set_node;
      if ($urandom_range(0, 9) == 0) r.len = 8'd0;
      else if (r.len == 0) r.len = 8'd1;
      r.sb[7] = ($urandom_range(0, 99) < 8);
      r.sb[0] = ($urandom_range(0, 99) < 20);
      r.sb[1] = ($urandom_range(0, 99) < 40);
    end else begin
      r.op = OP_UNUSED;
    end
    return r;
  endfunction

  task automatic run_random_traffic(input int count);
    for (int i = 0; i < count; i++) send_request(random_request());
  endtask

  // Reset values, ignored messages, the unused opcode and the zero-level reseed.
  task automatic test_reset_state();
    send_request(req(OP_UNUSED, 255, 255, 255, 255));
    send_request(req(OP_TICK, 0, 0, 0, 0));
    send_request(req(OP_STATUS, 0, 255, 0, 0));
    send_request(req(OP_STATUS, 0, 254, 1, 0));
    send_request(req(OP_CONTROL, 0, 0, 0, 0));
    send_request(req(OP_CONTROL, 255, 0, 0, 0));
    send_request(req(OP_STATUS, 0, 255, 255, 255));
    wait_for_results();
  endtask

  // Walk the mode machine through pump, both timeouts, the error mode and
  // the forced return to wait.
  task automatic test_mode_walk();
    load_settings(2, 3, 1000, 0, 210, 205, 0, 'h5A);
    send_request(req(OP_STATUS, 0, 'h5A, 1, 0));
    send_request(req(OP_CONTROL, 250, 0, 0, 0));
    repeat (3) send_request(req(OP_TICK, 0, 0, 0, 0));
    send_request(req(OP_CONTROL, 250, 0, 0, 0));
    send_request(req(OP_CONTROL, 250, 0, 0, 0));
    send_request(req(OP_STATUS, 0, 'h5A, 1, 'h80));
    send_request(req(OP_CONTROL, 250, 0, 0, 0));
    send_request(req(OP_STATUS, 0, 'h5A, 1, 0));
    send_request(req(OP_CONTROL, 250, 0, 0, 0));
    send_request(req(OP_CONTROL, 0, 0, 0, 0));
    send_request(req(OP_CONTROL, 0, 0, 0, 0));
    repeat (4) send_request(req(OP_TICK, 0, 0, 0, 0));
    send_request(req(OP_CONTROL, 0, 0, 0, 0));
    send_request(req(OP_STATUS, 0, 'h5A, 1, 3));
    send_request(req(OP_CONTROL, 0, 0, 0, 0));
    wait_for_results();
  endtask

  // Random traffic under several settings, the extremes among them.
  task automatic test_setting_sweep();
    int ex;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: load_settings(int'(RST_PUMP_TIMEOUT), int'(RST_REFILL_TIMEOUT), 8,
                         int'(RST_EMPTY_COOLDOWN), int'(RST_EMPTY_EXIT_LEVEL),
                         int'(RST_EMPTY_ENTER_LEVEL), int'(RST_VARIANCE_MARGIN),
                         int'(RST_ACCEPT_NODE));
        1: load_settings(0, 0, 0, 0, 0, 0, 0, 0);
        2: load_settings('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF);
        default: begin
          ex = $urandom_range(190, 235);
          load_settings($urandom_range(0, 40), $urandom_range(0, 80), $urandom_range(1, 24),
                        $urandom_range(0, 12), ex | ($urandom_range(0, 255) << 8),
                        $urandom_range(175, ex), $urandom_range(0, 20) | ($urandom << 8),
                        $urandom_range(0, 65535));
        end
      endcase
      sink_style = $urandom_range(0, 2);
      steady_feed = (phase == 3);
      run_random_traffic(SWEEP_ITEMS);
      steady_feed = 1'b0;
      wait_for_results();
    end
  endtask

  // The sink holds off while the sender keeps offering, so the input stalls.
  task automatic test_backpressure();
    load_settings(20, 40, 10, 3, 212, 200, 5, 'h21);
    sink_style = 1;
    steady_feed = 1'b1;
    hold_token++;
    run_random_traffic(40);
    steady_feed = 1'b0;
    wait_for_results();
  endtask

  // Enough ticks to saturate every elapsed counter; a wrap would make the
  // status fresh again and the cooldown active again.
  task automatic test_counter_saturation();
    load_settings(int'(CNT_MAX), int'(CNT_MAX), int'(CNT_MAX), int'(CNT_MAX),
                  210, 205, 255, 7);
    sink_style = 0;
    steady_feed = 1'b1;
    send_request(req(OP_STATUS, 0, 7, 1, 0));
    send_request(req(OP_CONTROL, 250, 0, 0, 0));
    for (int i = 0; i < (1 << COUNTER_WIDTH) + 4; i++)
      send_request(req(OP_TICK, $urandom, $urandom, $urandom, $urandom));
    send_request(req(OP_CONTROL, 250, 0, 0, 0));
    send_request(req(OP_STATUS, 0, 7, 1, 0));
    send_request(req(OP_CONTROL, 250, 0, 0, 0));
    send_request(req(OP_CONTROL, 250, 0, 0, 0));
    steady_feed = 1'b0;
    wait_for_results();
  endtask

  initial begin
    reset_plant();
    sink_style = 2;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_mode_walk();
    test_setting_sweep();
    test_backpressure();
    test_counter_saturation();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
